// ----- rtl/core/uart_rb_pkg.sv -----
// Package for the UART register block: sizes, register map, bit positions,
// transfer structs and the control structs between the block's parts.
// No dependencies.
package uart_rb_pkg;

  localparam int RX_DEPTH  = 16;
  localparam int REG_WORDS = 64;

  localparam int RX_AW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_CW  = $clog2(RX_DEPTH + 1);
  localparam int REG_AW = $clog2(REG_WORDS);
  localparam int IDX_W  = 6;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2
  } kind_e_t;

  localparam logic [IDX_W-1:0] IDX_VERID = 6'd0;
  localparam logic [IDX_W-1:0] IDX_PARAM = 6'd1;
  localparam logic [IDX_W-1:0] IDX_STAT  = 6'd5;
  localparam logic [IDX_W-1:0] IDX_CTRL  = 6'd6;
  localparam logic [IDX_W-1:0] IDX_DATA  = 6'd7;
  localparam logic [IDX_W-1:0] IDX_FIFO  = 6'd10;

  localparam int ST_TDRE_BIT = 23;
  localparam int ST_TC_BIT   = 22;
  localparam int ST_RDRF_BIT = 21;
  localparam logic [31:0] ST_W1C_MASK = 32'h001F_0000;

  localparam int CT_TIE_BIT = 23;
  localparam int CT_RIE_BIT = 21;
  localparam int CT_TE_BIT  = 19;
  localparam int CT_RE_BIT  = 18;

  localparam int FF_TXFE_BIT = 23;
  localparam int FF_RXFE_BIT = 22;

  localparam logic [31:0] VERID_VALUE = 32'h0403_0003;
  localparam logic [31:0] PARAM_VALUE = 32'h0000_0F0F;
  localparam logic [31:0] STAT_RESET  = (32'd1 << ST_TDRE_BIT) | (32'd1 << ST_TC_BIT);
  localparam logic [31:0] FIFO_RESET  = (32'd1 << FF_TXFE_BIT) | (32'd1 << FF_RXFE_BIT);

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] reg_index;
    logic [31:0]      write_data;
    logic [7:0]       rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_level;
  } out_item_t;

  // top -> receive FIFO
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_byte;
  } rxf_ctrl_t;

  // receive FIFO -> top
  typedef struct packed {
    logic       nonempty;
    logic       last;
    logic       full;
    logic [7:0] head_data;
  } rxf_stat_t;

  // top -> register file
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [31:0]       data;
  } regf_wr_t;

endpackage

// ----- rtl/core/uart_rb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uart_rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/uart_rb_rx_fifo.sv -----
// Receive FIFO: head pointer, fill count and byte store with registered head read.
// Depends on uart_rb_pkg and uart_rb_ram.
module uart_rb_rx_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uart_rb_pkg::rxf_ctrl_t ctrl,
  output uart_rb_pkg::rxf_stat_t stat
);
  import uart_rb_pkg::*;

  logic [RX_AW-1:0] head_r, head_nxt;
  logic [RX_CW-1:0] count_r, count_nxt;
  logic [RX_CW:0]   tail_sum;
  logic [RX_AW-1:0] tail;
  logic [7:0]       ram_q;
  logic             byp_r;
  logic [7:0]       byp_data_r;

  always_comb begin
    tail_sum = {1'b0, {(RX_CW - RX_AW){1'b0}}, head_r} + {1'b0, count_r};
    if (tail_sum >= (RX_CW + 1)'(RX_DEPTH)) begin
      tail_sum = tail_sum - (RX_CW + 1)'(RX_DEPTH);
    end
    tail = tail_sum[RX_AW-1:0];

    head_nxt = head_r;
    if (ctrl.pop) begin
      head_nxt = (head_r == RX_AW'(RX_DEPTH - 1)) ? '0 : head_r + RX_AW'(1);
    end
    count_nxt = count_r + RX_CW'(ctrl.push) - RX_CW'(ctrl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      // a push landing on the new head is not yet visible in the RAM read
      byp_r   <= ctrl.push && (tail == head_nxt);
    end
    byp_data_r <= ctrl.push_byte;
  end

  // read the new head every cycle so the head byte is always ready
  uart_rb_ram #(
    .WIDTH(8),
    .DEPTH(RX_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ctrl.push),
    .waddr(tail),
    .wdata(ctrl.push_byte),
    .raddr(head_nxt),
    .rdata(ram_q)
  );

  assign stat.nonempty  = (count_r != '0);
  assign stat.last      = (count_r == RX_CW'(1));
  assign stat.full      = (count_r == RX_CW'(RX_DEPTH));
  assign stat.head_data = byp_r ? byp_data_r : ram_q;

endmodule

// ----- rtl/core/uart_rb_regfile.sv -----
// Plain storage words of the register map, in RAM with per-word valid bits
// (unwritten words read zero) and a bypass for a write to the word being read.
// Depends on uart_rb_pkg and uart_rb_ram.
module uart_rb_regfile (
  input  logic                            clk,
  input  logic                            rst_n,
  input  uart_rb_pkg::regf_wr_t           wr,
  input  logic [uart_rb_pkg::REG_AW-1:0]  rd_addr,
  output logic [31:0]                     rd_data
);
  import uart_rb_pkg::*;

  logic [REG_WORDS-1:0] valid_r;
  logic                 rd_valid_r;
  logic                 byp_r;
  logic [31:0]          byp_data_r;
  logic [31:0]          ram_q;
  logic                 hit;

  assign hit = wr.en && (wr.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr] || hit;
      byp_r      <= hit;
    end
    byp_data_r <= wr.data;
  end

  uart_rb_ram #(
    .WIDTH(32),
    .DEPTH(REG_WORDS)
  ) u_words (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  assign rd_data = !rd_valid_r ? 32'd0 : (byp_r ? byp_data_r : ram_q);

endmodule

// ----- rtl/core/uart_register_block_with_rx_fifo_unit.sv -----
// Top level of the UART register block with receive FIFO.
// Depends on uart_rb_pkg, uart_rb_regfile and uart_rb_rx_fifo.
//
//   channel   ports                        transfer when
//   input     start, busy, in_payload      start && !busy at a rising edge
//   result    out_valid, out_payload       out_valid high (one cycle strobe)
//
// One item enters per cycle while reset is released; the input/RAM read register
// loads at the accepting edge, the result register loads from it, and the result
// strobe is registered alongside the result.
// busy is low whenever reset is released; there is no clearing pass.
// The receiver cannot stall: every accepted item yields exactly one result.
// Reset is synchronous; the store words and FIFO bytes are not cleared.
module uart_register_block_with_rx_fifo_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  uart_rb_pkg::in_item_t  in_payload,
  output logic                   out_valid,
  output uart_rb_pkg::out_item_t out_payload
);
  import uart_rb_pkg::*;

  logic             stg_valid_r;
  in_item_t         stg_item_r;
  logic [31:0]      stat_r, stat_nxt;
  logic [31:0]      ctrl_r, ctrl_nxt;
  logic [31:0]      fifo_r, fifo_nxt;
  logic             irq_r, irq_nxt;
  logic             out_valid_r;
  out_item_t        out_payload_r, res;
  rxf_ctrl_t        rxf_ctrl;
  rxf_stat_t        rxf_stat;
  regf_wr_t         rf_wr;
  logic [31:0]      rf_rdata;
  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             accept;

  function automatic logic irq_calc(input logic [31:0] ctl, input logic [31:0] st);
    return (ctl[CT_TIE_BIT] & st[ST_TDRE_BIT]) | (ctl[CT_RIE_BIT] & st[ST_RDRF_BIT]);
  endfunction

  assign busy   = !rst_n;
  assign accept = start && !busy;

  uart_rb_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (rf_wr),
    .rd_addr(in_payload.reg_index[REG_AW-1:0]),
    .rd_data(rf_rdata)
  );

  uart_rb_rx_fifo u_rx_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (rxf_ctrl),
    .stat (rxf_stat)
  );

  assign idx      = stg_item_r.reg_index;
  assign in_range = int'(idx) < REG_WORDS;

  always_comb begin
    stat_nxt = stat_r;
    ctrl_nxt = ctrl_r;
    fifo_nxt = fifo_r;
    irq_nxt  = irq_r;
    res      = '0;
    rxf_ctrl = '0;
    rf_wr    = '0;
    rf_wr.addr      = idx[REG_AW-1:0];
    rf_wr.data      = stg_item_r.write_data;
    rxf_ctrl.push_byte = stg_item_r.rx_byte;

    if (stg_valid_r) begin
      case (kind_e_t'(stg_item_r.kind))
        KIND_READ: begin
          if (in_range) begin
            case (idx)
              IDX_VERID: res.read_data = VERID_VALUE;
              IDX_PARAM: res.read_data = PARAM_VALUE;
              IDX_DATA: begin
                if (rxf_stat.nonempty) begin
                  res.read_data = {24'd0, rxf_stat.head_data};
                  rxf_ctrl.pop  = 1'b1;
                  if (rxf_stat.last) begin
                    stat_nxt[ST_RDRF_BIT] = 1'b0;
                  end
                end
              end
              IDX_STAT: begin
                stat_nxt[ST_TDRE_BIT] = 1'b1;
                stat_nxt[ST_TC_BIT]   = 1'b1;
                if (rxf_stat.nonempty) begin
                  stat_nxt[ST_RDRF_BIT] = 1'b1;
                end
                res.read_data = stat_nxt;
              end
              IDX_CTRL: res.read_data = ctrl_r;
              IDX_FIFO: res.read_data = fifo_r;
              default:  res.read_data = rf_rdata;
            endcase
          end
        end
        KIND_WRITE: begin
          if (in_range) begin
            case (idx)
              IDX_DATA: begin
                if (ctrl_r[CT_TE_BIT]) begin
                  res.tx_valid = 1'b1;
                  res.tx_byte  = stg_item_r.write_data[7:0];
                end
              end
              IDX_STAT: stat_nxt = stat_r & ~(stg_item_r.write_data & ST_W1C_MASK);
              IDX_CTRL: begin
                ctrl_nxt = stg_item_r.write_data;
                irq_nxt  = irq_calc(stg_item_r.write_data, stat_r);
              end
              IDX_FIFO: fifo_nxt = stg_item_r.write_data;
              default:  rf_wr.en = 1'b1;
            endcase
          end
        end
        KIND_RX: begin
          if (ctrl_r[CT_RE_BIT]) begin
            // drop the byte when full, but still flag and re-evaluate the interrupt
            rxf_ctrl.push = !rxf_stat.full;
            stat_nxt[ST_RDRF_BIT] = 1'b1;
            irq_nxt = irq_calc(ctrl_r, stat_nxt);
          end
        end
        default: ;
      endcase
    end
    res.irq_level = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      stat_r      <= STAT_RESET;
      ctrl_r      <= '0;
      fifo_r      <= FIFO_RESET;
      irq_r       <= 1'b0;
    end else begin
      stg_valid_r <= accept;
      out_valid_r <= stg_valid_r;
      stat_r      <= stat_nxt;
      ctrl_r      <= ctrl_nxt;
      fifo_r      <= fifo_nxt;
      irq_r       <= irq_nxt;
    end
    if (accept) begin
      stg_item_r <= in_payload;
    end
    out_payload_r <= res;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  // every accepted transfer yields a result strobe
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted transfer did not produce a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid_r |=> !out_valid)
    else $error("result strobe without a transfer");

  a_tx_needs_te: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload.tx_valid) |-> ctrl_r[CT_TE_BIT])
    else $error("transmit byte sent with transmitter disabled");

  a_irq_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid_r |=> $stable(irq_r))
    else $error("interrupt level changed with no transfer");

endmodule
